// File: rtl/core/tal_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and the allocation table for the thruster allocation limiter
// no dependencies
package tal_pkg;

    localparam int N_AX    = 6;
    localparam int N_TH    = 6;
    localparam int IN_W    = 16;
    localparam int COEF_W  = 18;
    localparam int PROD_W  = IN_W + COEF_W;
    localparam int ACC_W   = PROD_W + 3;
    localparam int T_W     = 21;
    localparam int MAG_W   = 20;
    localparam int LIM_W   = 16;
    localparam int Q_W     = 16;
    localparam int DEN_W   = MAG_W + 1;
    localparam int NUM_W   = 38;
    localparam int DIV_STG = 4;
    localparam int DIV_BPS = Q_W / DIV_STG;

    // register index codes (paddr[3:2])
    localparam logic [1:0] REG_NEG_LIMIT = 2'd0;
    localparam logic [1:0] REG_POS_LIMIT = 2'd1;
    localparam logic [1:0] REG_DEAD_BAND = 2'd2;

    // rows thrusters, columns fx fy fz mx my mz, q.12
    localparam logic signed [COEF_W-1:0] COEF [N_TH][N_AX] = '{
        '{ 18'sd0,     -18'sd4096,  18'sd0,     18'sd0,      18'sd0,      18'sd0     },
        '{ 18'sd2048,  -18'sd1505,  18'sd0,     18'sd0,      18'sd0,      18'sd27416 },
        '{ 18'sd2048,   18'sd1505,  18'sd0,     18'sd0,      18'sd0,     -18'sd27416 },
        '{ 18'sd0,      18'sd0,     18'sd0,    -18'sd22567, -18'sd22567,  18'sd0     },
        '{ 18'sd0,      18'sd0,    -18'sd2048,  18'sd41225,  18'sd11284,  18'sd0     },
        '{ 18'sd0,      18'sd0,    -18'sd2048, -18'sd18658,  18'sd11284,  18'sd0     }
    };

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } thr_t;

    typedef thr_t [N_TH-1:0] thr_vec_t;

    typedef struct packed {
        logic             scale;
        logic [MAG_W-1:0] bm;
        logic [LIM_W-1:0] bl;
    } best_t;

    typedef struct packed {
        logic [LIM_W-1:0]  lim_pos;
        logic [LIM_W-1:0]  lim_neg;
        logic [LIM_W-2:0]  dead_band;
        logic [LIM_W-2:0]  cap;
    } lim_cfg_t;

endpackage

// File: rtl/core/tal_mix.sv
`timescale 1ns / 1ps
// wrench times allocation table: product stage and sum/round stage
// depends on tal_pkg
module tal_mix (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [tal_pkg::N_AX-1:0][tal_pkg::IN_W-1:0] wrench,
    output logic                                out_valid,
    output tal_pkg::thr_vec_t                   thr
);

    logic signed [tal_pkg::PROD_W-1:0] prod_reg [tal_pkg::N_TH][tal_pkg::N_AX];
    logic                              va_reg;
    logic                              vb_reg;
    tal_pkg::thr_vec_t                 thr_reg;
    tal_pkg::thr_vec_t                 thr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < tal_pkg::N_TH; i++) begin
                for (int j = 0; j < tal_pkg::N_AX; j++) begin
                    prod_reg[i][j] <= $signed(wrench[j]) * tal_pkg::COEF[i][j];
                end
            end
        end
    end

    // sum, round half up, floor shift
    always_comb begin
        logic signed [tal_pkg::ACC_W-1:0] acc;
        logic signed [tal_pkg::T_W-1:0]   t;
        for (int i = 0; i < tal_pkg::N_TH; i++) begin
            acc = tal_pkg::ACC_W'(2048);
            for (int j = 0; j < tal_pkg::N_AX; j++) begin
                acc = acc + tal_pkg::ACC_W'(prod_reg[i][j]);
            end
            t = tal_pkg::T_W'(acc >>> 12);
            thr_next[i].neg = t[tal_pkg::T_W-1];
            thr_next[i].mag = t[tal_pkg::T_W-1] ? tal_pkg::MAG_W'(-t)
                                                : tal_pkg::MAG_W'(t);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            thr_reg <= thr_next;
        end
    end

    assign out_valid = vb_reg;
    assign thr       = thr_reg;

endmodule

// File: rtl/core/tal_select.sv
`timescale 1ns / 1ps
// finds the thruster with the largest magnitude/limit ratio above one, registered tree
// depends on tal_pkg
module tal_select (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  tal_pkg::thr_vec_t    thr_in,
    input  tal_pkg::lim_cfg_t    cfg,
    output logic                 out_valid,
    output tal_pkg::thr_vec_t    thr_out,
    output tal_pkg::best_t       best
);

    typedef struct packed {
        logic                      e;
        logic [tal_pkg::MAG_W-1:0] m;
        logic [tal_pkg::LIM_W-1:0] l;
    } cand_t;

    function automatic cand_t pick(cand_t a, cand_t b);
        logic [tal_pkg::MAG_W+tal_pkg::LIM_W-1:0] pb;
        logic [tal_pkg::MAG_W+tal_pkg::LIM_W-1:0] pa;
        pb = b.m * a.l;
        pa = a.m * b.l;
        if (b.e && (!a.e || pb > pa)) begin
            return b;
        end
        return a;
    endfunction

    logic [3:0]        v_reg;
    tal_pkg::thr_vec_t thr_reg [4];
    cand_t             c0_reg [tal_pkg::N_TH];
    cand_t             c1_reg [3];
    cand_t             c2_reg [2];
    cand_t             c3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            thr_reg[0] <= thr_in;
            for (int k = 1; k < 4; k++) begin
                thr_reg[k] <= thr_reg[k-1];
            end
            // per-lane limit and exceed flag
            for (int i = 0; i < tal_pkg::N_TH; i++) begin
                c0_reg[i].m <= thr_in[i].mag;
                c0_reg[i].l <= thr_in[i].neg ? cfg.lim_neg : cfg.lim_pos;
                c0_reg[i].e <= (thr_in[i].mag != '0) &&
                               (thr_in[i].mag > tal_pkg::MAG_W'(thr_in[i].neg ? cfg.lim_neg
                                                                      : cfg.lim_pos));
            end
            // lower index wins ties
            c1_reg[0] <= pick(c0_reg[0], c0_reg[1]);
            c1_reg[1] <= pick(c0_reg[2], c0_reg[3]);
            c1_reg[2] <= pick(c0_reg[4], c0_reg[5]);
            c2_reg[0] <= pick(c1_reg[0], c1_reg[1]);
            c2_reg[1] <= c1_reg[2];
            c3_reg    <= pick(c2_reg[0], c2_reg[1]);
        end
    end

    assign out_valid  = v_reg[3];
    assign thr_out    = thr_reg[3];
    assign best.scale = c3_reg.e;
    assign best.bm    = c3_reg.m;
    assign best.bl    = c3_reg.l;

endmodule

// File: rtl/core/tal_div.sv
`timescale 1ns / 1ps
// scales thrusts by limit/worst magnitude if needed: numerator stage, radix-16 restoring divider
// depends on tal_pkg
module tal_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  tal_pkg::thr_vec_t    thr_in,
    input  tal_pkg::best_t       best,
    output logic                 out_valid,
    output tal_pkg::thr_vec_t    thr_out
);

    localparam int NS = tal_pkg::DIV_STG + 1;

    function automatic logic [tal_pkg::NUM_W+tal_pkg::DIV_BPS-1:0] div_step(
        logic [tal_pkg::NUM_W-1:0] r_in,
        logic [tal_pkg::DEN_W-1:0] d,
        int                        k
    );
        logic [tal_pkg::NUM_W-1:0]   r;
        logic [tal_pkg::NUM_W-1:0]   trial;
        logic [tal_pkg::DIV_BPS-1:0] bits;
        r = r_in;
        bits = '0;
        for (int b = tal_pkg::DIV_BPS - 1; b >= 0; b--) begin
            trial = tal_pkg::NUM_W'(d) << (tal_pkg::Q_W - tal_pkg::DIV_BPS * (k + 1) + b);
            if (r >= trial) begin
                r = r - trial;
                bits[b] = 1'b1;
            end
        end
        return {r, bits};
    endfunction

    logic [NS-1:0]             v_reg;
    logic [tal_pkg::NUM_W-1:0] rem_reg [NS][tal_pkg::N_TH];
    logic [tal_pkg::Q_W-1:0]   q_reg   [NS][tal_pkg::N_TH];
    logic [tal_pkg::DEN_W-1:0] den_reg [NS];
    logic                      scl_reg [NS];
    tal_pkg::thr_vec_t         thr_reg [NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        logic [tal_pkg::NUM_W+tal_pkg::DIV_BPS-1:0] st;
        logic [tal_pkg::MAG_W+tal_pkg::LIM_W-1:0]   prd;
        if (en) begin
            // numerator 2*m*L + M, denominator 2*M
            for (int i = 0; i < tal_pkg::N_TH; i++) begin
                prd = thr_in[i].mag * best.bl;
                rem_reg[0][i] <= tal_pkg::NUM_W'({prd, 1'b0})
                                 + tal_pkg::NUM_W'(best.bm);
                q_reg[0][i]   <= '0;
            end
            den_reg[0] <= {best.bm, 1'b0};
            scl_reg[0] <= best.scale;
            thr_reg[0] <= thr_in;
            for (int k = 0; k < tal_pkg::DIV_STG; k++) begin
                for (int i = 0; i < tal_pkg::N_TH; i++) begin
                    st = div_step(rem_reg[k][i], den_reg[k], k);
                    rem_reg[k+1][i] <= st[tal_pkg::NUM_W+tal_pkg::DIV_BPS-1:tal_pkg::DIV_BPS];
                    q_reg[k+1][i]   <= {q_reg[k][i][tal_pkg::Q_W-tal_pkg::DIV_BPS-1:0],
                                        st[tal_pkg::DIV_BPS-1:0]};
                end
                den_reg[k+1] <= den_reg[k];
                scl_reg[k+1] <= scl_reg[k];
                thr_reg[k+1] <= thr_reg[k];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < tal_pkg::N_TH; i++) begin
            thr_out[i].neg = thr_reg[NS-1][i].neg;
            thr_out[i].mag = scl_reg[NS-1] ? tal_pkg::MAG_W'(q_reg[NS-1][i])
                                           : thr_reg[NS-1][i].mag;
        end
    end

    assign out_valid = v_reg[NS-1];

endmodule

// File: rtl/core/tal_shape.sv
`timescale 1ns / 1ps
// dead band raise, cap clamp and the output register
// depends on tal_pkg
module tal_shape (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  tal_pkg::thr_vec_t    thr_in,
    input  tal_pkg::lim_cfg_t    cfg,
    output logic                 out_valid,
    output logic [tal_pkg::N_TH*tal_pkg::IN_W-1:0] out_data
);

    logic                                   v_reg;
    logic [tal_pkg::N_TH*tal_pkg::IN_W-1:0] data_reg;
    logic [tal_pkg::N_TH*tal_pkg::IN_W-1:0] data_next;

    always_comb begin
        logic [tal_pkg::MAG_W-1:0] v;
        for (int i = 0; i < tal_pkg::N_TH; i++) begin
            v = thr_in[i].mag;
            if (v != '0 && v < tal_pkg::MAG_W'(cfg.dead_band)) begin
                v = tal_pkg::MAG_W'(cfg.dead_band);
            end
            if (v > tal_pkg::MAG_W'(cfg.cap)) begin
                v = tal_pkg::MAG_W'(cfg.cap);
            end
            data_next[i*tal_pkg::IN_W +: tal_pkg::IN_W] =
                thr_in[i].neg ? tal_pkg::IN_W'(-v) : tal_pkg::IN_W'(v);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/thruster_allocation_limiter.sv
`timescale 1ns / 1ps
// top level of the thruster allocation limiter: config registers and pipeline control
// depends on tal_pkg, tal_mix, tal_select, tal_div, tal_shape
//
//  channel   dir  signals                       payload
//  s_        in   s_tvalid s_tready s_tdata     wrench, six signed q7.8 values
//  m_        out  m_tvalid m_tready m_tdata     six thruster commands, signed q7.8
//  apb       in   psel penable pwrite paddr ... negative limit, positive limit, dead band
//
// one wrench per cycle enters while the output is not stalled; the stages are the matrix,
// the ratio tree, the numerator and divider and the output register, with the depth set
// by the radix-16 divider and the ratio compare tree
// aresetn is synchronous, active low; it clears the valid bits and restores
// the register defaults
// the whole pipeline holds when the output transfer is stalled, so s_tready
// follows the output slot being free
module thruster_allocation_limiter (
    input  logic        aclk,
    input  logic        aresetn,
    // force_x, force_y, force_z, torque_x, torque_y, torque_z, 16 bits each, lowest first
    input  logic [95:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // thrust_one .. thrust_six, 16 bits each, lowest first
    output logic [95:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config registers plus derived limits
    logic [15:0]       neg_thr_reg;
    logic [14:0]       pos_thr_reg;
    tal_pkg::lim_cfg_t cfg_reg;

    logic              en;
    logic              wr_en;
    logic [1:0]        reg_idx;
    logic [16:0]       cap_x;
    logic [32:0]       cap_prod;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // 0.8 * max rounded: (4*max + 2) / 5 via reciprocal 52429 / 2^18
    assign cap_x    = {pwdata[14:0], 2'b10};
    assign cap_prod = cap_x * 16'd52429;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_thr_reg       <= 16'hD800;
            pos_thr_reg       <= 15'd10240;
            cfg_reg.lim_neg   <= 16'd10240;
            cfg_reg.lim_pos   <= 16'd10240;
            cfg_reg.dead_band <= 15'd256;
            cfg_reg.cap       <= 15'd8192;
        end else if (wr_en) begin
            case (reg_idx)
                tal_pkg::REG_NEG_LIMIT: begin
                    neg_thr_reg     <= pwdata[15:0];
                    // nonnegative limit counts as one lsb
                    cfg_reg.lim_neg <= pwdata[15] ? 16'(-pwdata[15:0]) : 16'd1;
                end
                tal_pkg::REG_POS_LIMIT: begin
                    pos_thr_reg     <= pwdata[14:0];
                    cfg_reg.lim_pos <= (pwdata[14:0] == '0) ? 16'd1 : {1'b0, pwdata[14:0]};
                    cfg_reg.cap     <= cap_prod[32:18];
                end
                tal_pkg::REG_DEAD_BAND: begin
                    cfg_reg.dead_band <= pwdata[14:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tal_pkg::REG_NEG_LIMIT: prdata = {{16{neg_thr_reg[15]}}, neg_thr_reg};
            tal_pkg::REG_POS_LIMIT: prdata = {17'd0, pos_thr_reg};
            tal_pkg::REG_DEAD_BAND: prdata = {17'd0, cfg_reg.dead_band};
            default:                prdata = '0;
        endcase
    end

    // pipeline advances whenever the output slot is free or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic              mix_valid;
    tal_pkg::thr_vec_t mix_thr;
    logic              sel_valid;
    tal_pkg::thr_vec_t sel_thr;
    tal_pkg::best_t    sel_best;
    logic              div_valid;
    tal_pkg::thr_vec_t div_thr;

    tal_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .wrench    (s_tdata),
        .out_valid (mix_valid),
        .thr       (mix_thr)
    );

    tal_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mix_valid),
        .thr_in    (mix_thr),
        .cfg       (cfg_reg),
        .out_valid (sel_valid),
        .thr_out   (sel_thr),
        .best      (sel_best)
    );

    tal_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sel_valid),
        .thr_in    (sel_thr),
        .best      (sel_best),
        .out_valid (div_valid),
        .thr_out   (div_thr)
    );

    tal_shape u_shape (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .thr_in    (div_thr),
        .cfg       (cfg_reg),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

// File: tb/thruster_allocation_limiter_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the thruster allocation limiter: stream traffic with
// random idling on both sides, register writes between phases, result prediction
// depends on tal_pkg and thruster_allocation_limiter
module thruster_allocation_limiter_tb;

    // thrust predictor and the queue of thrust vectors still owed by the block
    class thrust_board;
        logic signed [15:0] neg_limit_reg;
        logic [14:0]        pos_limit_reg;
        logic [14:0]        dead_band_reg;
        logic [95:0]        owed_thrusts[$];
        int                 errors;

        function void set_defaults();
            neg_limit_reg = -16'sd10240;
            pos_limit_reg = 15'd10240;
            dead_band_reg = 15'd256;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                tal_pkg::REG_NEG_LIMIT: neg_limit_reg = value[15:0];
                tal_pkg::REG_POS_LIMIT: pos_limit_reg = value[14:0];
                tal_pkg::REG_DEAD_BAND: dead_band_reg = value[14:0];
                default: ;
            endcase
        endfunction

        function logic [95:0] allocate(logic [95:0] wrench);
            longint t[tal_pkg::N_TH];
            longint acc, m, l, q, bm, bl, lneg, lpos, cap, v;
            int worst;
            logic [95:0] thrusts;
            worst = -1;
            bm = 0;
            bl = 1;
            for (int i = 0; i < tal_pkg::N_TH; i++) begin
                acc = 0;
                for (int j = 0; j < tal_pkg::N_AX; j++)
                    acc += longint'(tal_pkg::COEF[i][j])
                           * longint'($signed(wrench[16*j +: 16]));
                t[i] = (acc + 2048) >>> 12;   // round half up to q7.8
            end
            lneg = (neg_limit_reg < 0) ? -longint'(neg_limit_reg) : 1;
            lpos = (pos_limit_reg > 0) ? longint'(pos_limit_reg) : 1;
            // worst thruster: largest magnitude over limit ratio above one
            for (int i = 0; i < tal_pkg::N_TH; i++) begin
                if (t[i] != 0) begin
                    m = (t[i] < 0) ? -t[i] : t[i];
                    l = (t[i] > 0) ? lpos : lneg;
                    if (m > l && (worst < 0 || m * bl > bm * l)) begin
                        worst = i;
                        bm = m;
                        bl = l;
                    end
                end
            end
            if (worst >= 0) begin
                for (int i = 0; i < tal_pkg::N_TH; i++) begin
                    m = (t[i] < 0) ? -t[i] : t[i];
                    q = (m * bl * 2 + bm) / (bm * 2);
                    t[i] = (t[i] < 0) ? -q : q;
                end
            end
            cap = (longint'(pos_limit_reg) * 4 + 2) / 5;
            for (int i = 0; i < tal_pkg::N_TH; i++) begin
                v = t[i];
                m = (v < 0) ? -v : v;
                if (v != 0 && m < longint'(dead_band_reg))
                    v = (v > 0) ? longint'(dead_band_reg) : -longint'(dead_band_reg);
                m = (v < 0) ? -v : v;
                if (m > cap)
                    v = (v > 0) ? cap : -cap;
                thrusts[16*i +: 16] = v[15:0];
            end
            return thrusts;
        endfunction

        function void note_wrench(logic [95:0] wrench);
            owed_thrusts = {owed_thrusts, allocate(wrench)};
        endfunction

        function void check_thrusts(logic [95:0] got);
            logic [95:0] want;
            if (owed_thrusts.size() == 0) begin
                $display("%0t: unexpected thrust transfer %h", $time, got);
                errors++;
                return;
            end
            want = owed_thrusts.pop_front();
            for (int i = 0; i < tal_pkg::N_TH; i++)
                if (want[16*i +: 16] !== got[16*i +: 16]) begin
                    $display("%0t: thrust %0d expected %0d actual %0d", $time, i + 1,
                             $signed(want[16*i +: 16]), $signed(got[16*i +: 16]));
                    errors++;
                end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic [95:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    thrust_board board;
    bit          calm;   // no idling on either side while set

    thruster_allocation_limiter dut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // result side: random stalls, every transfer checked against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= 23);
        if (aresetn && m_tvalid && m_tready)
            board.check_thrusts(m_tdata);
    end

    // apb write: setup cycle, then access cycle
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(int neg_lim, int pos_lim, int dead);
        write_reg(tal_pkg::REG_NEG_LIMIT, neg_lim);
        write_reg(tal_pkg::REG_POS_LIMIT, pos_lim);
        write_reg(tal_pkg::REG_DEAD_BAND, dead);
    endtask

    // one wrench transfer, idle cycles drawn one at a time beforehand
    task automatic send_wrench(logic [95:0] wrench);
        while (!calm && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= wrench;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_wrench(wrench);
    endtask

    // wait until every predicted thrust vector has arrived, then let the pipe empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.owed_thrusts.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    function automatic logic [95:0] same_axes(logic [15:0] v);
        return {6{v}};
    endfunction

    function automatic logic [95:0] one_axis(int axis, logic [15:0] v);
        logic [95:0] w;
        w = '0;
        w[16*axis +: 16] = v;
        return w;
    endfunction

    function automatic logic [95:0] random_wrench();
        logic [95:0] w;
        int          reach;
        // a third full range, the rest small to hit the dead band and no-scaling cases
        reach = $urandom_range(2);
        for (int j = 0; j < tal_pkg::N_AX; j++)
            case (reach)
                0: w[16*j +: 16] = 16'($urandom());
                1: w[16*j +: 16] = 16'($urandom_range(1200) - 600);
                default: w[16*j +: 16] = ($urandom_range(3) == 0) ? 16'd0
                                         : 16'($urandom_range(60) - 30);
            endcase
        return w;
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) begin
            calm = (k >= count / 3) && (k < count / 2);
            send_wrench(random_wrench());
        end
        calm = 1'b0;
    endtask

    initial begin
        board    = new();
        board.set_defaults();
        calm     = 1'b0;
        aresetn  = 1'b0;
        s_tdata  = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero wrench, field extremes, each axis alone, tiny demands
        send_wrench('0);
        send_wrench(same_axes(16'h7fff));
        send_wrench(same_axes(16'h8000));
        send_wrench(same_axes(16'hffff));
        send_wrench(same_axes(16'h0001));
        for (int j = 0; j < tal_pkg::N_AX; j++) begin
            send_wrench(one_axis(j, 16'h7fff));
            send_wrench(one_axis(j, 16'h8000));
            send_wrench(one_axis(j, 16'd3));
        end
        random_phase(240);
        drain();

        // widest limits, no dead band
        set_limits(-32767, 32767, 0);
        send_wrench(same_axes(16'h7fff));
        send_wrench(same_axes(16'h0001));
        random_phase(240);
        drain();

        // narrowest limits, dead band far above the cap
        set_limits(-1, 1, 32767);
        send_wrench('0);
        send_wrench(one_axis(0, 16'h0001));
        random_phase(240);
        drain();

        // uneven limits, moderate dead band
        set_limits(-256, 512, 100);
        random_phase(240);
        drain();

        set_limits(-$urandom_range(32767, 1), $urandom_range(32767, 1), $urandom_range(32767));
        random_phase(240);
        drain();

        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.owed_thrusts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/core/tal_pkg.sv
rtl/core/tal_mix.sv
rtl/core/tal_select.sv
rtl/core/tal_div.sv
rtl/core/tal_shape.sv
rtl/core/thruster_allocation_limiter.sv
tb/thruster_allocation_limiter_tb.sv
